[design/plob_pkg.sv]
// Shared types, codes and sizes for the price level order book.
`default_nettype none
package plob_pkg;

    localparam int LEVELS      = 64;
    localparam int ORDER_SLOTS = 1024;

    localparam int SLOT_W  = $clog2(ORDER_SLOTS);
    localparam int SLOT_CW = $clog2(ORDER_SLOTS + 1);
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int LVL_CW  = $clog2(LEVELS + 1);
    localparam int QTY_W   = 40;

    localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_TRADE  = 3'd3;

    localparam logic [3:0] STS_OK           = 4'd0;
    localparam logic [3:0] STS_BAD_SIDE     = 4'd1;
    localparam logic [3:0] STS_BAD_ACTION   = 4'd2;
    localparam logic [3:0] STS_DUP_ID       = 4'd3;
    localparam logic [3:0] STS_CXL_UNKNOWN  = 4'd4;
    localparam logic [3:0] STS_CXL_MISMATCH = 4'd5;
    localparam logic [3:0] STS_CXL_LOW      = 4'd6;
    localparam logic [3:0] STS_CXL_NO_LVL   = 4'd7;
    localparam logic [3:0] STS_MOD_UNKNOWN  = 4'd8;
    localparam logic [3:0] STS_MOD_PRICE    = 4'd9;
    localparam logic [3:0] STS_MOD_LOW      = 4'd10;
    localparam logic [3:0] STS_MOD_NO_LVL   = 4'd11;
    localparam logic [3:0] STS_NO_ROOM      = 4'd12;

    localparam logic [2:0] UPD_NONE    = 3'd0;
    localparam logic [2:0] UPD_ADDED   = 3'd1;
    localparam logic [2:0] UPD_CHANGED = 3'd2;
    localparam logic [2:0] UPD_REMOVED = 3'd3;
    localparam logic [2:0] UPD_TRADE   = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_EV,
        S_LVL_CHK,
        S_LVL_RD,
        S_LVL_EV,
        S_DECIDE,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_REM_CHK,
        S_REM_RD,
        S_REM_WR
    } t_state;

    typedef struct packed {
        logic [1:0]  side;
        logic [31:0] key;
        logic [31:0] qty;
        logic [31:0] price;
    } t_slot;

    typedef struct packed {
        logic [31:0]      price;
        logic [QTY_W-1:0] qty;
    } t_level;

    function automatic logic [QTY_W-1:0] sat_qty(input logic [QTY_W:0] s);
        sat_qty = s[QTY_W] ? QTY_MAX : s[QTY_W-1:0];
    endfunction

endpackage
`default_nettype wire

[design/price_level_order_book.sv]
// Top level: order table and price level lists held in memories with one write and one read port.
// Usage
//   Request channel: drive operation, side, order_id, qty, price and raise start;
//   the request is taken on a clock edge where start is high and busy is low.
//   Result channel: o_result_valid is high for exactly one cycle with status and
//   the level update; the receiver cannot stall it, so it must sample then.
// Sequence
//   Trade, unknown action and unknown side: result in the cycle after the request,
//   and a new request may follow in the very next cycle.
//   Add, cancel, modify: the order table is scanned slot by slot (read, then
//   compare) over up to ORDER_SLOTS slots; then the side's levels are scanned
//   level by level (check, read, compare) up to the price; a decision follows,
//   and an inserted or removed level moves each later level one entry at a time
//   (check, read, write) before the result is reported; busy stays high until then.
//   The slot scan through the order table memory sets the rate.
// Reset
//   After reset the block runs a clearing pass over all ORDER_SLOTS slots of the
//   order table with busy high; both level lists start empty.
`default_nettype none
module price_level_order_book (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [1:0]  i_side,
    input  wire logic [31:0] i_order_id,
    input  wire logic [31:0] i_qty,
    input  wire logic [31:0] i_price,
    output logic             o_result_valid,
    output logic [3:0]       o_status,
    output logic [2:0]       o_update_kind,
    output logic             o_update_side,
    output logic [5:0]       o_level_index,
    output logic [39:0]      o_level_qty,
    output logic [31:0]      o_level_price
);

    localparam int SW  = plob_pkg::SLOT_W;
    localparam int SCW = plob_pkg::SLOT_CW;
    localparam int LW  = plob_pkg::LVL_W;
    localparam int LCW = plob_pkg::LVL_CW;
    localparam int QW  = plob_pkg::QTY_W;

    plob_pkg::t_slot  slot_mem [plob_pkg::ORDER_SLOTS];
    plob_pkg::t_level lvl_mem  [2**(LW+1)];

    plob_pkg::t_state r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic             r_side, n_side;
    logic [31:0]      r_id, n_id, r_qty, n_qty, r_price, n_price;
    logic [SCW-1:0]   r_scnt, n_scnt;
    logic [SW-1:0]    r_hidx, n_hidx, r_fidx, n_fidx;
    logic [31:0]      r_hqty, n_hqty, r_hprice, n_hprice;
    logic             r_fre, n_fre;
    logic [LCW-1:0]   r_lcnt, n_lcnt, r_sh, n_sh;
    logic             r_lfound, n_lfound;
    logic [QW-1:0]    r_lqty, n_lqty;
    logic [LCW-1:0]   r_bcnt, n_bcnt, r_acnt, n_acnt;
    logic             r_ovld, n_ovld;
    logic [3:0]       r_status, n_status;
    logic [2:0]       r_kind, n_kind;
    logic             r_oside, n_oside;
    logic [LW-1:0]    r_oidx, n_oidx;
    logic [QW-1:0]    r_oqty, n_oqty;
    logic [31:0]      r_oprice, n_oprice;

    plob_pkg::t_slot  r_srd;
    plob_pkg::t_level r_lrd;

    logic             w_swe, w_lwe;
    logic [SW-1:0]    w_swa;
    plob_pkg::t_slot  w_swd;
    logic [LW:0]      w_lwa, w_lra;
    plob_pkg::t_level w_lwd;
    logic [LCW-1:0]   w_lra_idx;

    // decision terms
    logic             w_accept, w_quick;
    logic             w_match, w_free, w_last, w_bad_hit;
    logic [LCW-1:0]   w_cnt;
    logic             w_better, w_fail, w_insert, w_remove;
    logic [3:0]       w_fail_sts;
    logic [QW-1:0]    w_newq, w_dif;
    logic [LW+5:0]    w_idx_ext;

    assign busy     = (r_state != plob_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_quick  = (i_operation >= plob_pkg::OP_TRADE) || (i_side > 2'd1);
    assign w_cnt    = r_side ? r_acnt : r_bcnt;
    assign w_last   = (r_scnt == SCW'(plob_pkg::ORDER_SLOTS - 1));

    always_comb begin
        w_free  = (r_srd.side == 2'd0);
        w_match = !w_free && (r_srd.key == r_id) &&
                  ((r_op == plob_pkg::OP_ADD) || (r_srd.side == {1'b0, r_side} + 2'd1));
        if (r_op == plob_pkg::OP_CANCEL)
            w_bad_hit = (r_srd.qty != r_qty) || (r_srd.price != r_price);
        else
            w_bad_hit = (r_srd.price != r_price);
        w_better = r_side ? (r_lrd.price < r_price) : (r_lrd.price > r_price);
    end

    always_comb begin
        w_dif      = r_lqty - {8'd0, r_hqty};
        w_fail     = 1'b0;
        w_fail_sts = plob_pkg::STS_OK;
        w_newq     = {8'd0, r_qty};
        unique case (r_op)
            plob_pkg::OP_ADD: begin
                w_fail     = !r_fre || (!r_lfound && (w_cnt >= LCW'(plob_pkg::LEVELS)));
                w_fail_sts = plob_pkg::STS_NO_ROOM;
                if (r_lfound)
                    w_newq = plob_pkg::sat_qty({1'b0, r_lqty} + {9'd0, r_qty});
            end
            plob_pkg::OP_CANCEL: begin
                w_fail     = !r_lfound || (r_lqty < {8'd0, r_qty});
                w_fail_sts = !r_lfound ? plob_pkg::STS_CXL_NO_LVL : plob_pkg::STS_CXL_LOW;
                w_newq     = r_lqty - {8'd0, r_qty};
            end
            default: begin
                w_fail     = !r_lfound || (r_lqty < {8'd0, r_hqty});
                w_fail_sts = !r_lfound ? plob_pkg::STS_MOD_NO_LVL : plob_pkg::STS_MOD_LOW;
                w_newq     = plob_pkg::sat_qty({1'b0, w_dif} + {9'd0, r_qty});
            end
        endcase
        w_insert = (r_op == plob_pkg::OP_ADD) && !r_lfound;
        w_remove = (r_op != plob_pkg::OP_ADD) && (w_newq == '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plob_pkg::S_CLEAR:
                if (w_last) n_state = plob_pkg::S_IDLE;
            plob_pkg::S_IDLE:
                if (w_accept && !w_quick) n_state = plob_pkg::S_SLOT_RD;
            plob_pkg::S_SLOT_RD:
                n_state = plob_pkg::S_SLOT_EV;
            plob_pkg::S_SLOT_EV: begin
                if (r_op == plob_pkg::OP_ADD) begin
                    if (w_match)     n_state = plob_pkg::S_IDLE;
                    else if (w_last) n_state = plob_pkg::S_LVL_CHK;
                    else             n_state = plob_pkg::S_SLOT_RD;
                end else begin
                    if (w_match)     n_state = w_bad_hit ? plob_pkg::S_IDLE
                                                         : plob_pkg::S_LVL_CHK;
                    else if (w_last) n_state = plob_pkg::S_IDLE;
                    else             n_state = plob_pkg::S_SLOT_RD;
                end
            end
            plob_pkg::S_LVL_CHK:
                n_state = (r_lcnt >= w_cnt) ? plob_pkg::S_DECIDE : plob_pkg::S_LVL_RD;
            plob_pkg::S_LVL_RD:
                n_state = plob_pkg::S_LVL_EV;
            plob_pkg::S_LVL_EV:
                n_state = w_better ? plob_pkg::S_LVL_CHK : plob_pkg::S_DECIDE;
            plob_pkg::S_DECIDE: begin
                if (w_fail)        n_state = plob_pkg::S_IDLE;
                else if (w_insert) n_state = plob_pkg::S_INS_CHK;
                else if (w_remove) n_state = plob_pkg::S_REM_CHK;
                else               n_state = plob_pkg::S_IDLE;
            end
            plob_pkg::S_INS_CHK:
                n_state = (r_sh == r_lcnt) ? plob_pkg::S_IDLE : plob_pkg::S_INS_RD;
            plob_pkg::S_INS_RD:
                n_state = plob_pkg::S_INS_WR;
            plob_pkg::S_INS_WR:
                n_state = plob_pkg::S_INS_CHK;
            plob_pkg::S_REM_CHK:
                n_state = ((r_sh + LCW'(1)) >= w_cnt) ? plob_pkg::S_IDLE : plob_pkg::S_REM_RD;
            plob_pkg::S_REM_RD:
                n_state = plob_pkg::S_REM_WR;
            plob_pkg::S_REM_WR:
                n_state = plob_pkg::S_REM_CHK;
            default:
                n_state = plob_pkg::S_IDLE;
        endcase
    end

    // datapath, memory control and results
    always_comb begin
        n_op = r_op;   n_side = r_side;   n_id = r_id;   n_qty = r_qty;
        n_price = r_price;   n_scnt = r_scnt;   n_hidx = r_hidx;   n_fidx = r_fidx;
        n_hqty = r_hqty;   n_hprice = r_hprice;   n_fre = r_fre;   n_lcnt = r_lcnt;
        n_sh = r_sh;   n_lfound = r_lfound;   n_lqty = r_lqty;
        n_bcnt = r_bcnt;   n_acnt = r_acnt;
        n_ovld = 1'b0;   n_status = plob_pkg::STS_OK;   n_kind = plob_pkg::UPD_NONE;
        n_oside = 1'b0;   n_oidx = '0;   n_oqty = '0;   n_oprice = '0;
        w_swe = 1'b0;   w_swa = r_scnt[SW-1:0];   w_swd = '0;
        w_lwe = 1'b0;   w_lwa = {r_side, r_lcnt[LW-1:0]};   w_lwd = r_lrd;
        w_lra_idx = r_lcnt;

        unique case (r_state)
            plob_pkg::S_CLEAR: begin
                w_swe  = 1'b1;
                n_scnt = r_scnt + SCW'(1);
            end
            plob_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_operation;
                    n_side   = i_side[0];
                    n_id     = i_order_id;
                    n_qty    = i_qty;
                    n_price  = i_price;
                    n_scnt   = '0;
                    n_fre    = 1'b0;
                    n_lcnt   = '0;
                    n_lfound = 1'b0;
                    if (i_operation == plob_pkg::OP_TRADE) begin
                        n_ovld   = 1'b1;
                        n_kind   = plob_pkg::UPD_TRADE;
                        n_oqty   = {8'd0, i_qty};
                        n_oprice = i_price;
                    end else if (i_operation > plob_pkg::OP_TRADE) begin
                        n_ovld   = 1'b1;
                        n_status = plob_pkg::STS_BAD_ACTION;
                    end else if (i_side > 2'd1) begin
                        n_ovld   = 1'b1;
                        n_status = plob_pkg::STS_BAD_SIDE;
                    end
                end
            end
            plob_pkg::S_SLOT_RD: begin
            end
            plob_pkg::S_SLOT_EV: begin
                n_scnt = r_scnt + SCW'(1);
                if (w_free && !r_fre) begin
                    n_fre  = 1'b1;
                    n_fidx = r_scnt[SW-1:0];
                end
                if (w_match) begin
                    n_hidx   = r_scnt[SW-1:0];
                    n_hqty   = r_srd.qty;
                    n_hprice = r_srd.price;
                end
                if (r_op == plob_pkg::OP_ADD) begin
                    if (w_match) begin
                        n_ovld   = 1'b1;
                        n_status = plob_pkg::STS_DUP_ID;
                    end
                end else if (w_match) begin
                    if (w_bad_hit) begin
                        n_ovld   = 1'b1;
                        n_status = (r_op == plob_pkg::OP_CANCEL) ? plob_pkg::STS_CXL_MISMATCH
                                                                 : plob_pkg::STS_MOD_PRICE;
                    end
                end else if (w_last) begin
                    n_ovld   = 1'b1;
                    n_status = (r_op == plob_pkg::OP_CANCEL) ? plob_pkg::STS_CXL_UNKNOWN
                                                             : plob_pkg::STS_MOD_UNKNOWN;
                end
            end
            plob_pkg::S_LVL_CHK: begin
            end
            plob_pkg::S_LVL_RD: begin
                w_lra_idx = r_lcnt;
            end
            plob_pkg::S_LVL_EV: begin
                if (w_better) begin
                    n_lcnt = r_lcnt + LCW'(1);
                end else begin
                    n_lfound = (r_lrd.price == r_price);
                    n_lqty   = r_lrd.qty;
                end
            end
            plob_pkg::S_DECIDE: begin
                n_lqty = w_newq;
                if (w_fail) begin
                    n_ovld   = 1'b1;
                    n_status = w_fail_sts;
                end else begin
                    w_swe = 1'b1;
                    unique case (r_op)
                        plob_pkg::OP_ADD: begin
                            w_swa = r_fidx;
                            w_swd = '{side: {1'b0, r_side} + 2'd1, key: r_id,
                                      qty: r_qty, price: r_price};
                        end
                        plob_pkg::OP_CANCEL: begin
                            w_swa = r_hidx;
                            w_swd = '{side: 2'd0, key: r_id, qty: r_hqty, price: r_hprice};
                        end
                        default: begin
                            w_swa = r_hidx;
                            w_swd = '{side: {1'b0, r_side} + 2'd1, key: r_id,
                                      qty: r_qty, price: r_hprice};
                        end
                    endcase
                    if (w_insert) begin
                        n_sh = w_cnt;
                    end else if (w_remove) begin
                        n_sh = r_lcnt;
                    end else begin
                        w_lwe    = 1'b1;
                        w_lwd    = '{price: r_price, qty: w_newq};
                        n_ovld   = 1'b1;
                        n_kind   = plob_pkg::UPD_CHANGED;
                        n_oside  = r_side;
                        n_oidx   = r_lcnt[LW-1:0];
                        n_oqty   = w_newq;
                        n_oprice = r_price;
                    end
                end
            end
            plob_pkg::S_INS_CHK: begin
                if (r_sh == r_lcnt) begin
                    w_lwe    = 1'b1;
                    w_lwd    = '{price: r_price, qty: r_lqty};
                    n_ovld   = 1'b1;
                    n_kind   = plob_pkg::UPD_ADDED;
                    n_oside  = r_side;
                    n_oidx   = r_lcnt[LW-1:0];
                    n_oqty   = r_lqty;
                    n_oprice = r_price;
                    if (r_side) n_acnt = r_acnt + LCW'(1);
                    else        n_bcnt = r_bcnt + LCW'(1);
                end
            end
            plob_pkg::S_INS_RD: begin
                w_lra_idx = r_sh - LCW'(1);
            end
            plob_pkg::S_INS_WR: begin
                // move level sh-1 down into sh
                w_lwe = 1'b1;
                w_lwa = {r_side, r_sh[LW-1:0]};
                w_lwd = r_lrd;
                n_sh  = r_sh - LCW'(1);
            end
            plob_pkg::S_REM_CHK: begin
                if ((r_sh + LCW'(1)) >= w_cnt) begin
                    n_ovld   = 1'b1;
                    n_kind   = plob_pkg::UPD_REMOVED;
                    n_oside  = r_side;
                    n_oidx   = r_lcnt[LW-1:0];
                    n_oprice = r_price;
                    if (r_side) n_acnt = r_acnt - LCW'(1);
                    else        n_bcnt = r_bcnt - LCW'(1);
                end
            end
            plob_pkg::S_REM_RD: begin
                w_lra_idx = r_sh + LCW'(1);
            end
            plob_pkg::S_REM_WR: begin
                w_lwe = 1'b1;
                w_lwa = {r_side, r_sh[LW-1:0]};
                w_lwd = r_lrd;
                n_sh  = r_sh + LCW'(1);
            end
            default: begin
            end
        endcase
        w_lra = {r_side, w_lra_idx[LW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_swe)
            slot_mem[w_swa] <= w_swd;
        r_srd <= slot_mem[r_scnt[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe)
            lvl_mem[w_lwa] <= w_lwd;
        r_lrd <= lvl_mem[w_lra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plob_pkg::S_CLEAR;
            r_scnt  <= '0;
            r_bcnt  <= '0;
            r_acnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scnt  <= n_scnt;
            r_bcnt  <= n_bcnt;
            r_acnt  <= n_acnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;     r_side   <= n_side;   r_id     <= n_id;
        r_qty    <= n_qty;    r_price  <= n_price;  r_hidx   <= n_hidx;
        r_fidx   <= n_fidx;   r_hqty   <= n_hqty;   r_hprice <= n_hprice;
        r_fre    <= n_fre;    r_lcnt   <= n_lcnt;   r_sh     <= n_sh;
        r_lfound <= n_lfound; r_lqty   <= n_lqty;
        r_status <= n_status; r_kind   <= n_kind;   r_oside  <= n_oside;
        r_oidx   <= n_oidx;   r_oqty   <= n_oqty;   r_oprice <= n_oprice;
    end

    assign w_idx_ext      = {6'd0, r_oidx};
    assign o_result_valid = r_ovld;
    assign o_status       = r_status;
    assign o_update_kind  = r_kind;
    assign o_update_side  = r_oside;
    assign o_level_index  = w_idx_ext[5:0];
    assign o_level_qty    = r_oqty;
    assign o_level_price  = r_oprice;

`ifndef SYNTHESIS
    a_err_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_status != plob_pkg::STS_OK)) |-> (r_kind == plob_pkg::UPD_NONE))
        else $error("error result carries a level update");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bcnt <= LCW'(plob_pkg::LEVELS)) && (r_acnt <= LCW'(plob_pkg::LEVELS)))
        else $error("level count beyond capacity");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("request taken before order table clear");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plob_pkg::S_INS_WR) |-> (r_sh > r_lcnt))
        else $error("insert shift past target level");
`endif

endmodule
`default_nettype wire

[tb/order_book_checker.sv]
// Checker for the price level order book: predicts every result and compares it.
module order_book_checker
    import plob_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [1:0]  i_side,
    input  wire logic [31:0] i_order_id,
    input  wire logic [31:0] i_qty,
    input  wire logic [31:0] i_price,
    input  wire logic        o_result_valid,
    input  wire logic [3:0]  o_status,
    input  wire logic [2:0]  o_update_kind,
    input  wire logic        o_update_side,
    input  wire logic [5:0]  o_level_index,
    input  wire logic [39:0] o_level_qty,
    input  wire logic [31:0] o_level_price,
    output int               n_fail,
    output int               n_pending,
    output int               n_checked
);

    typedef struct {
        logic [3:0]       status;
        logic [2:0]       kind;
        logic             side;
        logic [5:0]       index;
        logic [QTY_W-1:0] qty;
        logic [31:0]      price;
    } t_book_update;

    t_book_update pending_updates[$];

    // shadow book
    logic [31:0]      lvl_price [2][LEVELS];
    logic [QTY_W-1:0] lvl_qty   [2][LEVELS];
    int               lvl_count [2];
    logic [1:0]       slot_side [ORDER_SLOTS];
    logic [31:0]      slot_key  [ORDER_SLOTS];
    logic [31:0]      slot_qty  [ORDER_SLOTS];
    logic [31:0]      slot_price[ORDER_SLOTS];

    function automatic t_book_update make_update(logic [3:0] st, logic [2:0] kind, int s,
                                                 int idx, logic [QTY_W-1:0] q,
                                                 logic [31:0] p);
        t_book_update u;
        u.status = st;
        u.kind   = kind;
        u.side   = s[0];
        u.index  = idx[5:0];
        u.qty    = q;
        u.price  = p;
        return u;
    endfunction

    function automatic t_book_update error_update(logic [3:0] st);
        return make_update(st, UPD_NONE, 0, 0, '0, '0);
    endfunction

    // tag 0 matches either side
    function automatic int find_order(logic [31:0] id, logic [1:0] tag);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (slot_side[i] != 2'd0 && slot_key[i] == id && (tag == 2'd0 || slot_side[i] == tag))
                return i;
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (slot_side[i] == 2'd0)
                return i;
        return -1;
    endfunction

    function automatic int level_pos(int s, logic [31:0] p, output bit hit);
        int i;
        i = 0;
        while (i < lvl_count[s] && (s ? (lvl_price[s][i] < p) : (lvl_price[s][i] > p)))
            i++;
        hit = (i < lvl_count[s]) && (lvl_price[s][i] == p);
        return i;
    endfunction

    function automatic logic [QTY_W-1:0] add_sat(logic [QTY_W-1:0] a, logic [31:0] b);
        logic [QTY_W:0] sum;
        sum = {1'b0, a} + {9'd0, b};
        return sum[QTY_W] ? QTY_MAX : sum[QTY_W-1:0];
    endfunction

    // zero sum drops the level, otherwise report the new sum
    function automatic t_book_update settle_level(int s, int pos);
        logic [31:0] p;
        p = lvl_price[s][pos];
        if (lvl_qty[s][pos] == '0) begin
            for (int i = pos; i + 1 < lvl_count[s]; i++) begin
                lvl_price[s][i] = lvl_price[s][i+1];
                lvl_qty[s][i]   = lvl_qty[s][i+1];
            end
            lvl_count[s]--;
            return make_update(STS_OK, UPD_REMOVED, s, pos, '0, p);
        end
        return make_update(STS_OK, UPD_CHANGED, s, pos, lvl_qty[s][pos], p);
    endfunction

    function automatic t_book_update apply_request(logic [2:0] op, logic [1:0] sd,
                                                   logic [31:0] id, logic [31:0] q,
                                                   logic [31:0] p);
        int s, k, pos;
        bit hit;
        if (op == OP_TRADE)
            return make_update(STS_OK, UPD_TRADE, 0, 0, {8'd0, q}, p);
        if (op > OP_TRADE)
            return error_update(STS_BAD_ACTION);
        if (sd > 2'd1)
            return error_update(STS_BAD_SIDE);
        s = int'(sd);
        if (op == OP_ADD) begin
            if (find_order(id, 2'd0) >= 0)
                return error_update(STS_DUP_ID);
            pos = level_pos(s, p, hit);
            k = first_free_slot();
            if (k < 0 || (!hit && lvl_count[s] >= LEVELS))
                return error_update(STS_NO_ROOM);
            slot_side[k]  = sd + 2'd1;
            slot_key[k]   = id;
            slot_qty[k]   = q;
            slot_price[k] = p;
            if (!hit) begin
                for (int i = lvl_count[s]; i > pos; i--) begin
                    lvl_price[s][i] = lvl_price[s][i-1];
                    lvl_qty[s][i]   = lvl_qty[s][i-1];
                end
                lvl_price[s][pos] = p;
                lvl_qty[s][pos]   = {8'd0, q};
                lvl_count[s]++;
                return make_update(STS_OK, UPD_ADDED, s, pos, {8'd0, q}, p);
            end
            lvl_qty[s][pos] = add_sat(lvl_qty[s][pos], q);
            return make_update(STS_OK, UPD_CHANGED, s, pos, lvl_qty[s][pos], p);
        end
        k = find_order(id, sd + 2'd1);
        if (op == OP_CANCEL) begin
            if (k < 0)
                return error_update(STS_CXL_UNKNOWN);
            if (slot_qty[k] != q || slot_price[k] != p)
                return error_update(STS_CXL_MISMATCH);
            pos = level_pos(s, p, hit);
            if (!hit)
                return error_update(STS_CXL_NO_LVL);
            if (lvl_qty[s][pos] < {8'd0, q})
                return error_update(STS_CXL_LOW);
            lvl_qty[s][pos] = lvl_qty[s][pos] - {8'd0, q};
            slot_side[k] = 2'd0;
            return settle_level(s, pos);
        end
        if (k < 0)
            return error_update(STS_MOD_UNKNOWN);
        if (slot_price[k] != p)
            return error_update(STS_MOD_PRICE);
        pos = level_pos(s, p, hit);
        if (!hit)
            return error_update(STS_MOD_NO_LVL);
        if (lvl_qty[s][pos] < {8'd0, slot_qty[k]})
            return error_update(STS_MOD_LOW);
        lvl_qty[s][pos] = add_sat(lvl_qty[s][pos] - {8'd0, slot_qty[k]}, q);
        slot_qty[k] = q;
        return settle_level(s, pos);
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("checker: result %0d %s got 0x%0h want 0x%0h", n_checked, field, got, want);
        n_fail++;
    endtask

    initial begin
        n_fail = 0;
        n_checked = 0;
        n_pending = 0;
        lvl_count[0] = 0;
        lvl_count[1] = 0;
        for (int i = 0; i < ORDER_SLOTS; i++)
            slot_side[i] = 2'd0;
    end

    always @(posedge i_clk) begin
        t_book_update want;
        if (!i_rst_n) begin
            pending_updates.delete();
            lvl_count[0] = 0;
            lvl_count[1] = 0;
            for (int i = 0; i < ORDER_SLOTS; i++)
                slot_side[i] = 2'd0;
        end else begin
            // result first: a new request may be taken on the same edge
            if (o_result_valid) begin
                if (pending_updates.size() == 0) begin
                    report_mismatch("result_valid", 64'd1, 64'd0);
                end else begin
                    want = pending_updates.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_update_kind !== want.kind)
                        report_mismatch("update_kind", 64'(o_update_kind), 64'(want.kind));
                    if (o_update_side !== want.side)
                        report_mismatch("update_side", 64'(o_update_side), 64'(want.side));
                    if (o_level_index !== want.index)
                        report_mismatch("level_index", 64'(o_level_index), 64'(want.index));
                    if (o_level_qty !== want.qty)
                        report_mismatch("level_qty", 64'(o_level_qty), 64'(want.qty));
                    if (o_level_price !== want.price)
                        report_mismatch("level_price", 64'(o_level_price), 64'(want.price));
                end
                n_checked++;
            end
            if (start && !busy)
                pending_updates.insert(pending_updates.size(),
                                       apply_request(i_operation, i_side, i_order_id,
                                                     i_qty, i_price));
        end
        n_pending = pending_updates.size();
    end

endmodule

[tb/tb.sv]
// Testbench top: drives order requests into the book and gives the verdict.
module tb;
    import plob_pkg::*;

    localparam logic [1:0] SIDE_BUY  = 2'd0;
    localparam logic [1:0] SIDE_SELL = 2'd1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_operation = '0;
    logic [1:0]  i_side = '0;
    logic [31:0] i_order_id = '0;
    logic [31:0] i_qty = '0;
    logic [31:0] i_price = '0;
    logic        o_result_valid;
    logic [3:0]  o_status;
    logic [2:0]  o_update_kind;
    logic        o_update_side;
    logic [5:0]  o_level_index;
    logic [39:0] o_level_qty;
    logic [31:0] o_level_price;
    int          n_fail, n_pending, n_checked;

    typedef struct {
        logic [31:0] id;
        logic [1:0]  side;
        logic [31:0] qty;
        logic [31:0] price;
    } t_live_order;

    t_live_order live_orders[$];
    int  n_sent = 0;
    bit  allow_gaps = 1'b1;

    price_level_order_book dut (.*);

    order_book_checker checker_i (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #150_000_000;
        $display("Mismatches found");
        $finish;
    end

    // called at a falling edge; returns at a falling edge after acceptance, sometimes after an idle gap
    task automatic send_request(logic [2:0] op, logic [1:0] sd, logic [31:0] id,
                                logic [31:0] q, logic [31:0] p);
        i_operation = op;
        i_side      = sd;
        i_order_id  = id;
        i_qty       = q;
        i_price     = p;
        start       = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        n_sent++;
        @(negedge i_clk);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_price(logic [1:0] sd);
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return (sd == SIDE_BUY ? 32'd1000 : 32'd1030) + $urandom_range(0, 40);
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom();
            default: return $urandom_range(1, 500);
        endcase
    endfunction

    task automatic add_order(logic [31:0] q, logic [31:0] p);
        t_live_order o;
        o.id    = $urandom();
        o.side  = 2'($urandom_range(0, 1));
        o.qty   = q;
        o.price = p;
        live_orders.insert(live_orders.size(), o);
        send_request(OP_ADD, o.side, o.id, o.qty, o.price);
    endtask

    // mostly well-formed add/cancel/modify against known orders, some noise
    task automatic random_request();
        int w, i;
        logic [1:0] sd;
        logic [31:0] q;
        w = $urandom_range(0, 99);
        i = live_orders.size() ? $urandom_range(0, live_orders.size() - 1) : -1;
        sd = 2'($urandom_range(0, 1));
        if (w < 35 || i < 0) begin
            add_order(pick_qty(), pick_price(sd));
        end else if (w < 55) begin
            send_request(OP_CANCEL, live_orders[i].side, live_orders[i].id,
                         live_orders[i].qty, live_orders[i].price);
            live_orders.delete(i);
        end else if (w < 72) begin
            q = pick_qty();
            send_request(OP_MODIFY, live_orders[i].side, live_orders[i].id, q,
                         live_orders[i].price);
            live_orders[i].qty = q;
        end else if (w < 76) begin
            send_request(OP_ADD, 2'($urandom_range(0, 1)), live_orders[i].id, pick_qty(),
                         pick_price(sd));
        end else if (w < 82) begin
            send_request(3'($urandom_range(1, 2)), 2'($urandom_range(0, 3)), live_orders[i].id,
                         live_orders[i].qty ^ ($urandom_range(0, 1) << $urandom_range(0, 31)),
                         live_orders[i].price + $urandom_range(0, 1));
        end else if (w < 88) begin
            send_request(OP_TRADE, 2'($urandom_range(0, 3)), $urandom(), $urandom(),
                         $urandom());
        end else if (w < 93) begin
            send_request(3'($urandom_range(4, 7)), 2'($urandom_range(0, 3)), $urandom(),
                         $urandom(), $urandom());
        end else begin
            send_request(3'($urandom_range(0, 2)), 2'($urandom_range(2, 3)), $urandom(),
                         $urandom(), $urandom());
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(OP_TRADE, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_TRADE, 2'd3, 32'd0, 32'd0, 32'd0);
        send_request(3'd7, SIDE_SELL, 32'd1, 32'd1, 32'd1);
        send_request(3'd4, 2'd3, 32'd1, 32'd1, 32'd1);
        send_request(OP_ADD, 2'd2, 32'd9, 32'd9, 32'd9);
        send_request(OP_CANCEL, 2'd3, 32'd9, 32'd9, 32'd9);
        send_request(OP_MODIFY, 2'd2, 32'd9, 32'd9, 32'd9);
        send_request(OP_ADD, SIDE_BUY, 32'd0, 32'd0, 32'd0);
        send_request(OP_ADD, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ADD, SIDE_BUY, 32'd1, 32'd10, 32'd100);
        send_request(OP_ADD, SIDE_BUY, 32'd2, 32'd5, 32'd100);
        send_request(OP_ADD, SIDE_BUY, 32'd3, 32'd4, 32'd200);
        send_request(OP_ADD, SIDE_SELL, 32'd1, 32'd4, 32'd300);
        send_request(OP_CANCEL, SIDE_SELL, 32'd1, 32'd10, 32'd100);
        send_request(OP_CANCEL, SIDE_BUY, 32'd1, 32'd11, 32'd100);
        send_request(OP_CANCEL, SIDE_BUY, 32'd2, 32'd5, 32'd100);
        send_request(OP_MODIFY, SIDE_BUY, 32'd1, 32'd3, 32'd101);
        // modify to zero drops the level, the order stays behind with zero quantity
        send_request(OP_MODIFY, SIDE_BUY, 32'd1, 32'd0, 32'd100);
        send_request(OP_CANCEL, SIDE_BUY, 32'd1, 32'd0, 32'd100);
        send_request(OP_MODIFY, SIDE_BUY, 32'd1, 32'd7, 32'd100);
        send_request(OP_MODIFY, SIDE_SELL, 32'd77, 32'd7, 32'd100);
        send_request(OP_CANCEL, SIDE_BUY, 32'd3, 32'd4, 32'd200);
        send_request(OP_CANCEL, SIDE_BUY, 32'd0, 32'd0, 32'd0);

        repeat (200) random_request();

        // pile up orders, about half of them max-size, on eight prices: fills the table
        repeat (1130) begin
            if ($urandom_range(0, 9) == 0)
                random_request();
            else
                add_order($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom(),
                          32'd1000 + 8 * $urandom_range(0, 7));
        end

        repeat (100) random_request();
        allow_gaps = 1'b0;
        repeat (100) random_request();
        start = 1'b0;

        while (n_pending != 0)
            @(negedge i_clk);
        repeat (4200) @(negedge i_clk);

        $display("Sent %0d order requests, %0d results checked", n_sent, n_checked);
        $display("Covered add, cancel, modify, trade, bad codes and full-book cases");
        if (n_fail == 0 && n_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
